// ----- hw/rtl/ntcsh_pkg.sv -----
package ntcsh_pkg;

  // field and datapath widths
  localparam int unsigned VoltW     = 23;
  localparam int unsigned NumW      = 43;
  localparam int unsigned DenW      = 22;
  localparam int unsigned RfW       = 20;
  localparam int unsigned CoefW     = 48;
  localparam int unsigned LimW      = 16;
  localparam int unsigned LnW       = 30;
  localparam int unsigned ExpW      = 6;
  localparam int unsigned MantW     = 31;
  localparam int unsigned FracSteps = 28;
  localparam int unsigned LogLat    = FracSteps + 3;
  localparam int unsigned PolyLat   = 6;
  localparam int unsigned DivW      = 64;
  localparam int unsigned CfgIdxW   = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCoefA   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefB   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefC   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMode    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRf      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTempMin = 3'd5;
  localparam logic [CfgIdxW-1:0] RegTempMax = 3'd6;

  // circuit modes
  localparam logic [1:0] ModeBridge    = 2'd0;
  localparam logic [1:0] ModeDivTop    = 2'd1;
  localparam logic [1:0] ModeDivBottom = 2'd2;

  // circuit and conversion constants
  localparam logic signed [23:0] VrefUv      = 24'sd2500000;
  localparam logic signed [23:0] BridgeMidUv = 24'sd1250000;
  localparam logic [RfW-1:0]     BridgeROhms = 20'd100000;
  localparam logic [RfW-1:0]     RfReset     = 20'd10000;
  localparam logic signed [LimW-1:0] TempMinReset = -16'sd4000;
  localparam logic signed [LimW-1:0] TempMaxReset = 16'sd12500;
  localparam logic [31:0] Ln2Q32            = 32'd2977044472;
  localparam logic [DivW-1:0] KelvinNum     = 64'd7205759403792793600;
  localparam logic [15:0] KelvinOffsetCenti = 16'd27315;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StVolt = 2'd1,
    StTemp = 2'd2
  } status_e;

  typedef struct packed {
    logic    vld;
    status_e st;
  } ctl_t;

endpackage

// ----- hw/rtl/ntcsh_front.sv -----
module ntcsh_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 vld_i,
  input  logic signed [ntcsh_pkg::VoltW-1:0]   voltage_uv_i,
  input  logic [1:0]                           mode_i,
  input  logic [ntcsh_pkg::RfW-1:0]            rf_i,
  output ntcsh_pkg::ctl_t                      ctl_o,
  output logic [ntcsh_pkg::NumW-1:0]           num_o,
  output logic [ntcsh_pkg::DenW-1:0]           den_o
);

  logic signed [23:0]              v_ext;
  logic signed [23:0]              vn;
  logic [ntcsh_pkg::RfW-1:0]       mul_a_d, mul_a_q;
  logic [ntcsh_pkg::DenW-1:0]      mul_b_d, mul_b_q;
  logic [ntcsh_pkg::DenW-1:0]      den_d, den1_q, den2_q;
  logic                            in_rng;
  ntcsh_pkg::status_e              st_d;
  ntcsh_pkg::ctl_t                 ctl1_q, ctl2_q;
  logic [ntcsh_pkg::NumW-2:0]      prod;
  logic [ntcsh_pkg::NumW-1:0]      num_q;

  // range check and operand select per circuit
  always_comb begin
    v_ext   = {voltage_uv_i[ntcsh_pkg::VoltW-1], voltage_uv_i};
    vn      = v_ext + ntcsh_pkg::BridgeMidUv;
    mul_a_d = rf_i;
    mul_b_d = '0;
    den_d   = '0;
    in_rng  = 1'b0;
    unique case (mode_i)
      ntcsh_pkg::ModeBridge: begin
        in_rng  = (vn > 24'sd0) && (vn < ntcsh_pkg::VrefUv);
        mul_a_d = ntcsh_pkg::BridgeROhms;
        mul_b_d = 22'(ntcsh_pkg::VrefUv - vn);
        den_d   = 22'(vn);
      end
      ntcsh_pkg::ModeDivTop: begin
        in_rng  = (v_ext > 24'sd0) && (v_ext < ntcsh_pkg::VrefUv);
        mul_b_d = 22'(ntcsh_pkg::VrefUv - v_ext);
        den_d   = 22'(v_ext);
      end
      ntcsh_pkg::ModeDivBottom: begin
        in_rng  = (v_ext > 24'sd0) && (v_ext < ntcsh_pkg::VrefUv);
        mul_b_d = 22'(v_ext);
        den_d   = 22'(ntcsh_pkg::VrefUv - v_ext);
      end
      default: begin
        in_rng = 1'b0;
      end
    endcase
    priority if (!in_rng) begin
      st_d = ntcsh_pkg::StVolt;
    end else if (mul_a_d == '0) begin
      st_d = ntcsh_pkg::StTemp;
    end else begin
      st_d = ntcsh_pkg::StOk;
    end
  end

  assign prod = mul_a_q * mul_b_q;

  // valid and status stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= '{vld: vld_i, st: st_d};
      ctl2_q <= ctl1_q;
    end
  end

  // operand and product stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_a_q <= mul_a_d;
      mul_b_q <= mul_b_d;
      den1_q  <= den_d;
      num_q   <= {1'b0, prod};
      den2_q  <= den1_q;
    end
  end

  assign ctl_o = ctl2_q;
  assign num_o = num_q;
  assign den_o = den2_q;

endmodule

// ----- hw/rtl/ntcsh_log.sv -----
module ntcsh_log (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ntcsh_pkg::NumW-1:0]    n_i,
  output logic [ntcsh_pkg::LnW-1:0]     ln_o
);

  localparam int unsigned MW = ntcsh_pkg::MantW;
  localparam int unsigned FS = ntcsh_pkg::FracSteps;
  localparam int unsigned EW = ntcsh_pkg::ExpW;

  logic [EW-1:0]                  lead;
  logic [ntcsh_pkg::NumW-1:0]     n0_q;
  logic [EW-1:0]                  e0_q;
  logic [ntcsh_pkg::NumW+MW-2:0]  norm;
  logic [MW-1:0]                  x_q    [0:FS];
  logic [FS-1:0]                  frac_q [0:FS];
  logic [EW-1:0]                  e_q    [0:FS];
  logic [MW-1:0]                  x_d    [0:FS-1];
  logic [FS-1:0]                  frac_d [0:FS-1];
  logic [EW+FS+31:0]              scaled;
  logic [ntcsh_pkg::LnW-1:0]      ln_q;

  // leading one position
  always_comb begin
    lead = '0;
    for (int i = 0; i < ntcsh_pkg::NumW; i++) begin
      if (n_i[i]) begin
        lead = EW'(i);
      end
    end
  end

  // mantissa normalized to one integer bit and MW-1 fraction bits
  assign norm = {n0_q, {(MW-1){1'b0}}} >> e0_q;

  // one log2 fraction bit per squaring stage
  for (genvar k = 0; k < FS; k++) begin : g_sq
    logic [2*MW-1:0] sq;
    logic [MW:0]     t;
    assign sq        = x_q[k] * x_q[k];
    assign t         = sq[2*MW-1:MW-1];
    assign x_d[k]    = t[MW] ? t[MW:1] : t[MW-1:0];
    assign frac_d[k] = {frac_q[k][FS-2:0], t[MW]};
  end

  // log2 times ln2, rounded down to the fraction width
  assign scaled = {e_q[FS], frac_q[FS]} * ntcsh_pkg::Ln2Q32;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q      <= n_i;
      e0_q      <= lead;
      x_q[0]    <= norm[MW-1:0];
      frac_q[0] <= '0;
      e_q[0]    <= e0_q;
      for (int k = 0; k < FS; k++) begin
        x_q[k+1]    <= x_d[k];
        frac_q[k+1] <= frac_d[k];
        e_q[k+1]    <= e_q[k];
      end
      ln_q <= scaled[EW+FS+31:36];
    end
  end

  assign ln_o = ln_q;

endmodule

// ----- hw/rtl/ntcsh_poly.sv -----
module ntcsh_poly (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  ntcsh_pkg::ctl_t                     ctl_i,
  input  logic [ntcsh_pkg::LnW-1:0]           lnn_i,
  input  logic [ntcsh_pkg::LnW-1:0]           lnd_i,
  input  logic signed [ntcsh_pkg::CoefW-1:0]  coef_a_i,
  input  logic signed [ntcsh_pkg::CoefW-1:0]  coef_b_i,
  input  logic signed [ntcsh_pkg::CoefW-1:0]  coef_c_i,
  output ntcsh_pkg::ctl_t                     ctl_o,
  output logic signed [63:0]                  invt_o
);

  localparam int unsigned LW = ntcsh_pkg::LnW;

  ntcsh_pkg::ctl_t      ctl_q [0:ntcsh_pkg::PolyLat-1];
  logic signed [LW:0]   l_d;
  logic                 b_neg, c_neg;
  logic [47:0]          b_mag, c_mag;
  logic                 neg0_q, neg1_q, neg2_q, neg3_q;
  logic [LW-1:0]        mag0_q, mag1_q;
  logic [2*LW-1:0]      sq_d;
  logic [35:0]          l2_q;
  logic [53:0]          bl_lo_d, bl_lo_q, bl_hi_d;
  logic [77:0]          bl_full;
  logic signed [63:0]   bl_d, bl2_q, bl3_q, bl4_q;
  logic [65:0]          cube_d;
  logic [41:0]          l3_2_q, l3_3_q;
  logic [65:0]          cl_lo_d, cl_lo_q, cl_hi_d;
  logic [89:0]          cl_full;
  logic signed [63:0]   cl_d, cl4_q;
  logic signed [63:0]   invt_d, invt_q;
  ntcsh_pkg::ctl_t      ctl_d;

  // log difference as sign and magnitude
  assign l_d   = $signed({1'b0, lnn_i}) - $signed({1'b0, lnd_i});
  assign b_neg = coef_b_i[47];
  assign c_neg = coef_c_i[47];
  assign b_mag = b_neg ? 48'(-coef_b_i) : coef_b_i;
  assign c_mag = c_neg ? 48'(-coef_c_i) : coef_c_i;

  // square and low half of b times l
  assign sq_d    = mag0_q * mag0_q;
  assign bl_lo_d = b_mag[23:0] * mag0_q;

  // cube and b times l
  assign cube_d  = l2_q * mag1_q;
  assign bl_hi_d = b_mag[47:24] * mag1_q;
  assign bl_full = {bl_hi_d, 24'b0} + bl_lo_q;
  assign bl_d    = (neg1_q ^ b_neg) ? -64'({10'b0, bl_full[77:24]})
                                    : 64'({10'b0, bl_full[77:24]});

  // c times cube, split in two partial products
  assign cl_lo_d = c_mag[23:0] * l3_2_q;
  assign cl_hi_d = c_mag[47:24] * l3_3_q;
  assign cl_full = {cl_hi_d, 24'b0} + cl_lo_q;
  assign cl_d    = (neg3_q ^ c_neg) ? -64'({1'b0, cl_full[86:24]})
                                    : 64'({1'b0, cl_full[86:24]});

  // reciprocal temperature sum
  assign invt_d = 64'(coef_a_i) + bl4_q + cl4_q;

  always_comb begin
    ctl_d = ctl_q[ntcsh_pkg::PolyLat-2];
    if (ctl_d.st == ntcsh_pkg::StOk && invt_d <= 64'sd0) begin
      ctl_d.st = ntcsh_pkg::StTemp;
    end
  end

  // valid and status stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ntcsh_pkg::PolyLat; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < ntcsh_pkg::PolyLat - 1; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
      ctl_q[ntcsh_pkg::PolyLat-1] <= ctl_d;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg0_q  <= l_d[LW];
      mag0_q  <= l_d[LW] ? LW'(-l_d) : LW'(l_d);
      neg1_q  <= neg0_q;
      mag1_q  <= mag0_q;
      l2_q    <= sq_d[2*LW-1:24];
      bl_lo_q <= bl_lo_d;
      neg2_q  <= neg1_q;
      l3_2_q  <= cube_d[65:24];
      bl2_q   <= bl_d;
      neg3_q  <= neg2_q;
      l3_3_q  <= l3_2_q;
      cl_lo_q <= cl_lo_d;
      bl3_q   <= bl2_q;
      cl4_q   <= cl_d;
      bl4_q   <= bl3_q;
      invt_q  <= invt_d;
    end
  end

  // neg2_q only carries the cube sign forward
  assign ctl_o  = ctl_q[ntcsh_pkg::PolyLat-1];
  assign invt_o = invt_q;

endmodule

// ----- hw/rtl/ntcsh_div.sv -----
module ntcsh_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  ntcsh_pkg::ctl_t               ctl_i,
  input  logic signed [63:0]            invt_i,
  output ntcsh_pkg::ctl_t               ctl_o,
  output logic [ntcsh_pkg::DivW-1:0]    quo_o
);

  localparam int unsigned W = ntcsh_pkg::DivW;

  ntcsh_pkg::ctl_t  ctl_q [0:W];
  logic [W-1:0]     rem_q [0:W];
  logic [W-1:0]     qd_q  [0:W];
  logic [W-1:0]     dvs_q [0:W];
  logic [W-1:0]     rem_d [0:W-1];
  logic [W-1:0]     qd_d  [0:W-1];
  logic [W-1:0]     dvd;

  // dividend with half the divisor added for rounding
  assign dvd = ntcsh_pkg::KelvinNum + {1'b0, invt_i[63:1]};

  // one restoring quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;
    assign trial    = {rem_q[k], qd_q[k][W-1]};
    assign diff     = trial - {1'b0, dvs_q[k]};
    assign ge       = trial >= {1'b0, dvs_q[k]};
    assign rem_d[k] = ge ? diff[W-1:0] : trial[W-1:0];
    assign qd_d[k]  = {qd_q[k][W-2:0], ge};
  end

  // valid and status stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= W; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en_i) begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i <= W; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // divider stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      qd_q[0]  <= dvd;
      dvs_q[0] <= invt_i;
      for (int i = 0; i < W; i++) begin
        rem_q[i+1] <= rem_d[i];
        qd_q[i+1]  <= qd_d[i];
        dvs_q[i+1] <= dvs_q[i];
      end
    end
  end

  assign ctl_o = ctl_q[W];
  assign quo_o = qd_q[W];

endmodule

// ----- hw/rtl/ntc_steinhart_hart_temperature.sv -----
// throughput: one word per cycle, fully pipelined; the 64 one-bit divider stages
// and the 28 squaring stages of each log unit set the depth
// a stalled output word freezes the whole pipeline until it is taken
// reset clears all valid bits and loads the register defaults
module ntc_steinhart_hart_temperature (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ntcsh_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [ntcsh_pkg::CoefW-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ntcsh_pkg::VoltW-1:0]    voltage_uv_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ntcsh_pkg::LimW-1:0]     temperature_centi_o,
  output logic [1:0]                            status_o
);

  logic signed [ntcsh_pkg::CoefW-1:0]  coef_a_q, coef_b_q, coef_c_q;
  logic [1:0]                          mode_q;
  logic [ntcsh_pkg::RfW-1:0]           rf_q;
  logic signed [ntcsh_pkg::LimW-1:0]   temp_min_q, temp_max_q;

  logic                                en;
  ntcsh_pkg::ctl_t                     front_ctl, poly_ctl, div_ctl;
  ntcsh_pkg::ctl_t                     ctl_dly_q [0:ntcsh_pkg::LogLat-1];
  logic [ntcsh_pkg::NumW-1:0]          num;
  logic [ntcsh_pkg::DenW-1:0]          den;
  logic [ntcsh_pkg::LnW-1:0]           lnn, lnd;
  logic signed [63:0]                  invt;
  logic [ntcsh_pkg::DivW-1:0]          quo;

  logic signed [65:0]                  centi;
  logic                                lim_bad;
  ntcsh_pkg::status_e                  st_d, status_q;
  logic signed [ntcsh_pkg::LimW-1:0]   temp_d, temp_q;
  logic                                out_vld_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q   <= '0;
      coef_b_q   <= '0;
      coef_c_q   <= '0;
      mode_q     <= ntcsh_pkg::ModeBridge;
      rf_q       <= ntcsh_pkg::RfReset;
      temp_min_q <= ntcsh_pkg::TempMinReset;
      temp_max_q <= ntcsh_pkg::TempMaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ntcsh_pkg::RegCoefA:   coef_a_q   <= cfg_data_i;
        ntcsh_pkg::RegCoefB:   coef_b_q   <= cfg_data_i;
        ntcsh_pkg::RegCoefC:   coef_c_q   <= cfg_data_i;
        ntcsh_pkg::RegMode:    mode_q     <= cfg_data_i[1:0];
        ntcsh_pkg::RegRf:      rf_q       <= cfg_data_i[ntcsh_pkg::RfW-1:0];
        ntcsh_pkg::RegTempMin: temp_min_q <= cfg_data_i[ntcsh_pkg::LimW-1:0];
        ntcsh_pkg::RegTempMax: temp_max_q <= cfg_data_i[ntcsh_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register can take a word
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  ntcsh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (in_valid_i),
    .voltage_uv_i (voltage_uv_i),
    .mode_i       (mode_q),
    .rf_i         (rf_q),
    .ctl_o        (front_ctl),
    .num_o        (num),
    .den_o        (den)
  );

  ntcsh_log u_log_num (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (num),
    .ln_o  (lnn)
  );

  ntcsh_log u_log_den (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   ({{(ntcsh_pkg::NumW-ntcsh_pkg::DenW){1'b0}}, den}),
    .ln_o  (lnd)
  );

  // valid and status alongside the log units
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ntcsh_pkg::LogLat; i++) begin
        ctl_dly_q[i] <= '0;
      end
    end else if (en) begin
      ctl_dly_q[0] <= front_ctl;
      for (int i = 1; i < ntcsh_pkg::LogLat; i++) begin
        ctl_dly_q[i] <= ctl_dly_q[i-1];
      end
    end
  end

  ntcsh_poly u_poly (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (ctl_dly_q[ntcsh_pkg::LogLat-1]),
    .lnn_i    (lnn),
    .lnd_i    (lnd),
    .coef_a_i (coef_a_q),
    .coef_b_i (coef_b_q),
    .coef_c_i (coef_c_q),
    .ctl_o    (poly_ctl),
    .invt_o   (invt)
  );

  ntcsh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (poly_ctl),
    .invt_i (invt),
    .ctl_o  (div_ctl),
    .quo_o  (quo)
  );

  // kelvin to celsius, limit check and saturation
  always_comb begin
    centi   = $signed({2'b0, quo}) - $signed({50'b0, ntcsh_pkg::KelvinOffsetCenti});
    lim_bad = (centi < 66'(temp_min_q)) || (centi > 66'(temp_max_q));
    priority if (div_ctl.st != ntcsh_pkg::StOk) begin
      st_d = div_ctl.st;
    end else if (lim_bad) begin
      st_d = ntcsh_pkg::StTemp;
    end else begin
      st_d = ntcsh_pkg::StOk;
    end
    priority if (st_d != ntcsh_pkg::StOk) begin
      temp_d = '0;
    end else if (centi > 66'sd32767) begin
      temp_d = 16'sh7fff;
    end else if (centi < -66'sd32768) begin
      temp_d = -16'sh8000;
    end else begin
      temp_d = centi[ntcsh_pkg::LimW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_ctl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= st_d;
      temp_q   <= temp_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign temperature_centi_o = temp_q;
  assign status_o            = status_q;

  // a flagged word carries zero temperature
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ntcsh_pkg::StOk |-> temperature_centi_o == '0)
    else $error("flagged word with nonzero temperature");

  // a good word lies within the configured limits
  a_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ntcsh_pkg::StOk |->
      temperature_centi_o >= temp_min_q && temperature_centi_o <= temp_max_q)
    else $error("good word outside limits");

  // a stall holds the divider output in place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(div_ctl) && $stable(quo))
    else $error("pipeline moved during stall");

endmodule

// ----- sim/testbench.sv -----
module testbench;

  localparam int unsigned VoltW   = ntcsh_pkg::VoltW;
  localparam int unsigned LimW    = ntcsh_pkg::LimW;
  localparam int unsigned CoefW   = ntcsh_pkg::CoefW;
  localparam int unsigned CfgIdxW = ntcsh_pkg::CfgIdxW;
  localparam int unsigned RfW     = ntcsh_pkg::RfW;

  localparam longint CycleLimit = 2000000;
  localparam int     DrainWait  = 140;
  localparam longint VrefU      = 2500000;
  localparam longint MidU       = 1250000;
  localparam longint BridgeOhms = 100000;
  localparam longint OffsetC    = 27315;
  localparam longint Ln2Fix     = 64'sd2977044472;
  localparam logic [63:0] KelvinScale = 64'd7205759403792793600;

  typedef struct {
    logic signed [LimW-1:0] temp;
    ntcsh_pkg::status_e     st;
  } temp_word_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CoefW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [VoltW-1:0] voltage_uv_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [LimW-1:0] temperature_centi_o;
  logic [1:0] status_o;

  // shadow copy of the register file
  logic signed [CoefW-1:0] k_a, k_b, k_c;
  logic [1:0] cur_mode;
  logic [RfW-1:0] r_fix;
  logic signed [LimW-1:0] lim_lo, lim_hi;

  logic signed [VoltW-1:0] volt_q[$];
  temp_word_t temp_exp_q[$];
  int errors = 0;
  longint cycles = 0;
  bit in_taken = 1'b0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;

  ntc_steinhart_hart_temperature i_dut (
    .clk_i(clk), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .voltage_uv_i(voltage_uv_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .temperature_centi_o(temperature_centi_o), .status_o(status_o)
  );

  always #1 clk = ~clk;

  // (a*b) >> s on the full product, truncated toward zero
  function automatic longint mul_trunc(longint a, longint b, int s);
    logic [63:0] ua, ub, mag;
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    mag = p >> s;
    mag[63] = 1'b0;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // natural log in q24 via leading one plus squaring for the fraction bits
  function automatic longint ln_fix(logic [63:0] n);
    int e;
    logic [63:0] x, frac;
    e = 63;
    while (n[e] == 1'b0 && e > 0) e--;
    x = e <= 30 ? n << (30 - e) : n >> (e - 30);
    frac = '0;
    for (int i = 0; i < 28; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= 64'h8000_0000) begin
        frac[0] = 1'b1;
        x = x >> 1;
      end
    end
    return mul_trunc(longint'((64'(e) << 28) | frac), Ln2Fix, 36);
  endfunction

  function automatic temp_word_t thermistor_temp(logic signed [VoltW-1:0] v);
    temp_word_t r;
    longint vi, vn, l, l2, l3, invt, centi;
    logic [63:0] num, den, ui, q;
    r.temp = '0;
    r.st = ntcsh_pkg::StVolt;
    vi = v;
    if (cur_mode == ntcsh_pkg::ModeBridge) begin
      vn = vi + MidU;
      if (vn <= 0 || vn >= VrefU) return r;
      num = BridgeOhms * (VrefU - vn);
      den = vn;
    end else if (cur_mode == ntcsh_pkg::ModeDivTop ||
                 cur_mode == ntcsh_pkg::ModeDivBottom) begin
      if (vi <= 0 || vi >= VrefU) return r;
      if (cur_mode == ntcsh_pkg::ModeDivTop) begin
        num = longint'(r_fix) * (VrefU - vi);
        den = vi;
      end else begin
        num = longint'(r_fix) * vi;
        den = VrefU - vi;
      end
    end else begin
      return r;
    end
    r.st = ntcsh_pkg::StTemp;
    if (num == 0) return r;
    l = ln_fix(num) - ln_fix(den);
    l2 = mul_trunc(l, l, 24);
    l3 = mul_trunc(l2, l, 24);
    invt = longint'(k_a) + mul_trunc(longint'(k_b), l, 24) + mul_trunc(longint'(k_c), l3, 24);
    if (invt <= 0) return r;
    ui = invt;
    q = (KelvinScale + ui / 2) / ui;
    centi = longint'(q) - OffsetC;
    if (centi < longint'(lim_lo) || centi > longint'(lim_hi)) return r;
    if (centi > 32767) centi = 32767;
    if (centi < -32768) centi = -32768;
    r.temp = centi[15:0];
    r.st = ntcsh_pkg::StOk;
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] data);
    @(negedge clk);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk);
    cfg_we_i <= 1'b0;
    case (idx)
      ntcsh_pkg::RegCoefA:   k_a = data;
      ntcsh_pkg::RegCoefB:   k_b = data;
      ntcsh_pkg::RegCoefC:   k_c = data;
      ntcsh_pkg::RegMode:    cur_mode = data[1:0];
      ntcsh_pkg::RegRf:      r_fix = data[RfW-1:0];
      ntcsh_pkg::RegTempMin: lim_lo = data[LimW-1:0];
      ntcsh_pkg::RegTempMax: lim_hi = data[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(longint a, longint b, longint c, logic [1:0] mode,
                           int rf, int lo, int hi);
    write_reg(ntcsh_pkg::RegCoefA, a[CoefW-1:0]);
    write_reg(ntcsh_pkg::RegCoefB, b[CoefW-1:0]);
    write_reg(ntcsh_pkg::RegCoefC, c[CoefW-1:0]);
    write_reg(ntcsh_pkg::RegMode, CoefW'(mode));
    write_reg(ntcsh_pkg::RegRf, CoefW'(rf[RfW-1:0]));
    write_reg(ntcsh_pkg::RegTempMin, CoefW'(lo[LimW-1:0]));
    write_reg(ntcsh_pkg::RegTempMax, CoefW'(hi[LimW-1:0]));
  endtask

  // mostly in-range voltages for the active circuit, some noise and edges
  function automatic logic signed [VoltW-1:0] rand_volt();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return VoltW'($urandom);
    if (pick == 1) return VoltW'($urandom_range(0, 6) - 3 + (($urandom_range(0, 1)) ? 2500000 : 0));
    if (cur_mode == ntcsh_pkg::ModeBridge)
      return VoltW'(int'($urandom_range(0, 2499998)) - 1249999);
    return VoltW'($urandom_range(1, 2499999));
  endfunction

  task automatic run_random(int n);
    repeat (n) volt_q.push_back(rand_volt());
  endtask

  task automatic run_directed();
    int dv[] = '{-4194304, 4194303, -2500000, 2500000, 0, 1, -1, -1250000, 1250000,
                 -1249999, 1249999, 2499999, 1250001, 10, 2400000, -1200000, 600000};
    foreach (dv[i]) volt_q.push_back(VoltW'(dv[i]));
  endtask

  task automatic drain();
    while (volt_q.size() != 0 || in_valid_i || temp_exp_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // sender: one word offered at a time, held until taken
  always @(negedge clk) begin
    logic nv;
    logic signed [VoltW-1:0] nd;
    nv = in_valid_i;
    nd = voltage_uv_i;
    if (!rst_ni) begin
      nv = 1'b0;
    end else if (!in_valid_i || in_taken) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (volt_q.size() != 0) begin
        nv = 1'b1;
        nd = volt_q.pop_front();
        if (!no_gaps && $urandom_range(0, 3) == 0)
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      end
    end
    in_valid_i <= nv;
    voltage_uv_i <= nd;
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    logic nr;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nr = 1'b0;
    end else begin
      nr = 1'b1;
      if (!no_gaps && $urandom_range(0, 3) == 0)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    end
    out_ready_i <= nr;
  end

  // record accepted words and check results
  always @(posedge clk) begin
    temp_word_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) temp_exp_q.push_back(thermistor_temp(voltage_uv_i));
      if (out_valid_o && out_ready_i) begin
        if (temp_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word temp %0d status %0d", $time,
                   temperature_centi_o, status_o);
        end else begin
          want = temp_exp_q.pop_front();
          if (temperature_centi_o !== want.temp) begin
            errors++;
            $display("%0t: temperature expected %0d actual %0d", $time, want.temp,
                     temperature_centi_o);
          end
          if (status_o !== want.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
          end
        end
      end
    end
  end

  initial begin
    k_a = '0; k_b = '0; k_c = '0;
    cur_mode = ntcsh_pkg::ModeBridge;
    r_fix = ntcsh_pkg::RfReset;
    lim_lo = ntcsh_pkg::TempMinReset;
    lim_hi = ntcsh_pkg::TempMaxReset;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // reset defaults: zero coefficients give no valid temperature
    run_directed();
    drain();

    // typical 10k thermistor through the bridge, long output hold-off
    write_all(81364000000000, 16870000000000, 6317000000, ntcsh_pkg::ModeBridge, 10000,
              -4000, 12500);
    run_directed();
    drain();
    no_gaps = 1'b1;
    hold_req = 1'b1;
    run_random(300);
    drain();
    no_gaps = 1'b0;

    // full limits so saturation-free wide range passes
    write_all(81364000000000, 16870000000000, 6317000000, ntcsh_pkg::ModeBridge, 10000,
              -32768, 32767);
    run_random(200);
    drain();

    write_all(81364000000000, 16870000000000, 6317000000, ntcsh_pkg::ModeDivTop, 10000,
              -32768, 32767);
    run_directed();
    run_random(200);
    drain();

    write_all(81364000000000, 16870000000000, 6317000000, ntcsh_pkg::ModeDivBottom,
              1000000, -4000, 12500);
    run_random(180);
    drain();

    write_all(81364000000000, 16870000000000, 6317000000, ntcsh_pkg::ModeDivTop, 1,
              -32768, 32767);
    run_random(100);
    drain();

    // zero resistor and the unused circuit mode
    write_all(81364000000000, 16870000000000, 6317000000, ntcsh_pkg::ModeDivBottom, 0,
              -32768, 32767);
    run_random(50);
    drain();
    write_reg(ntcsh_pkg::RegMode, CoefW'(3));
    run_random(50);
    drain();

    // coefficient extremes
    write_all(140737488355327, -140737488355328, 140737488355327, ntcsh_pkg::ModeBridge,
              1048575, -32768, 32767);
    run_random(100);
    drain();
    write_all(-140737488355328, 140737488355327, -140737488355328, ntcsh_pkg::ModeDivTop,
              1048575, -32768, 32767);
    run_random(100);
    drain();

    // random coefficients near the useful scale, random circuit
    write_all(longint'($urandom_range(0, 32'h7fffffff)) * 40000,
              longint'($urandom_range(0, 32'h7fffffff)) * 8000,
              longint'($urandom) - 64'sd2147483648, 2'($urandom_range(0, 2)),
              $urandom_range(1, 1000000), -32768, 32767);
    run_random(100);
    drain();

    // inverted limits reject everything
    write_all(81364000000000, 16870000000000, 6317000000, ntcsh_pkg::ModeBridge, 10000,
              5000, -5000);
    run_random(50);
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
